### rtl/cfglex_pkg.sv
// Shared types, token and error codes, lexer mode codes and character helpers.
package cfglex_pkg;

  localparam int OFFSET_BITS_DEF = 24;
  localparam int TOK_W           = 24;
  localparam int MAX_TOKENS      = 3;
  localparam int FIFO_DEPTH      = 8;

  // Token kinds.
  localparam logic [3:0] K_EQ     = 4'd0;
  localparam logic [3:0] K_COLON  = 4'd1;
  localparam logic [3:0] K_LBRACE = 4'd2;
  localparam logic [3:0] K_RBRACE = 4'd3;
  localparam logic [3:0] K_GT     = 4'd4;
  localparam logic [3:0] K_GE     = 4'd5;
  localparam logic [3:0] K_LT     = 4'd6;
  localparam logic [3:0] K_LE     = 4'd7;
  localparam logic [3:0] K_QE     = 4'd8;
  localparam logic [3:0] K_NUM    = 4'd9;
  localparam logic [3:0] K_STR    = 4'd10;
  localparam logic [3:0] K_BOOL   = 4'd11;
  localparam logic [3:0] K_IDENT  = 4'd12;
  localparam logic [3:0] K_END    = 4'd13;
  localparam logic [3:0] K_ERROR  = 4'd14;

  // Error codes.
  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_LONE_QM  = 3'd1;
  localparam logic [2:0] E_DOT      = 3'd2;
  localparam logic [2:0] E_NUM_END  = 3'd3;
  localparam logic [2:0] E_OPEN_STR = 3'd4;
  localparam logic [2:0] E_BAD_CHAR = 3'd5;

  // Lexer modes.
  localparam logic [3:0] M_START   = 4'd0;
  localparam logic [3:0] M_IDLE    = 4'd1;
  localparam logic [3:0] M_COMMENT = 4'd2;
  localparam logic [3:0] M_GT      = 4'd3;
  localparam logic [3:0] M_LT      = 4'd4;
  localparam logic [3:0] M_QM      = 4'd5;
  localparam logic [3:0] M_NUM     = 4'd6;
  localparam logic [3:0] M_STR     = 4'd7;
  localparam logic [3:0] M_IDENT   = 4'd8;
  localparam logic [3:0] M_BOM1    = 4'd9;
  localparam logic [3:0] M_BOM2    = 4'd10;
  localparam logic [3:0] M_ERR     = 4'd11;

  // Keyword tracker codes for "yes" and "no".
  localparam logic [2:0] KW_NONE = 3'd0;
  localparam logic [2:0] KW_Y    = 3'd1;
  localparam logic [2:0] KW_YE   = 3'd2;
  localparam logic [2:0] KW_YES  = 3'd3;
  localparam logic [2:0] KW_N    = 3'd4;
  localparam logic [2:0] KW_NO   = 3'd5;

  // Characters.
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_O  = 8'h6F;
  localparam logic [7:0] CH_LOW_S  = 8'h73;
  localparam logic [7:0] CH_LOW_Y  = 8'h79;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BOM0   = 8'hEF;
  localparam logic [7:0] CH_BOM1   = 8'hBB;

  typedef struct packed {
    logic [3:0]       kind;
    logic [TOK_W-1:0] start;
    logic [TOK_W-1:0] length;
    logic [2:0]       code;
    logic             last;
  } token_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return (c == CH_UNDER) || is_digit(c) || is_letter(c);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

endpackage

### rtl/cfglex_core.sv
// Lexer state and the per-byte token decode, up to three tokens per byte.
module cfglex_core #(
  parameter int OFFSET_BITS = cfglex_pkg::OFFSET_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [7:0]                  c,
  input  logic                        fin,
  output logic [1:0]                  tok_cnt,
  output cfglex_pkg::token_t [2:0]    toks
);
  import cfglex_pkg::*;

  localparam int OB = OFFSET_BITS;

  logic [3:0]    mode;
  logic [OB-1:0] byte_offset;
  logic [OB-1:0] token_begin;
  logic          digit_seen;
  logic          dot_seen;
  logic          last_was_dot;
  logic [2:0]    keyword_match;

  logic [3:0]    mode_next;
  logic [OB-1:0] byte_offset_next;
  logic [OB-1:0] token_begin_next;
  logic          digit_seen_next;
  logic          dot_seen_next;
  logic          last_was_dot_next;
  logic [2:0]    keyword_match_next;

  logic [OB-1:0] p;
  logic [OB-1:0] p_end;

  // Result of treating the byte as the first byte of a new token.
  logic [3:0]    f_mode;
  logic [OB-1:0] f_tb;
  logic          f_ds;
  logic          f_dot;
  logic          f_lwd;
  logic [2:0]    f_kw;
  logic          f_emit;
  token_t        f_tok;

  // Values after the byte itself, before the end-of-text flush.
  logic [3:0]    m;
  logic [OB-1:0] tb;
  logic          ds;
  logic          dt;
  logic          lwd;
  logic [2:0]    kw;
  logic [1:0]    n;
  token_t [2:0]  tv;

  function automatic token_t mk(input logic [3:0] k, input logic [OB-1:0] s,
                                input logic [OB-1:0] l, input logic [2:0] e);
    token_t t;
    t.kind   = k;
    t.start  = TOK_W'(s);
    t.length = TOK_W'(l);
    t.code   = e;
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic logic [3:0] ident_kind(input logic [2:0] k);
    return (k == KW_YES || k == KW_NO) ? K_BOOL : K_IDENT;
  endfunction

  assign p     = byte_offset;
  assign p_end = byte_offset + OB'(1);

  always_comb begin
    f_mode = M_IDLE;
    f_tb   = token_begin;
    f_ds   = digit_seen;
    f_dot  = dot_seen;
    f_lwd  = last_was_dot;
    f_kw   = keyword_match;
    f_emit = 1'b0;
    f_tok  = mk(K_ERROR, p, '0, E_BAD_CHAR);
    if (!is_space(c)) begin
      f_tb = p;
      case (c)
        CH_HASH:   f_mode = M_COMMENT;
        CH_EQ: begin
          f_emit = 1'b1;
          f_tok  = mk(K_EQ, p, OB'(1), E_NONE);
        end
        CH_COLON: begin
          f_emit = 1'b1;
          f_tok  = mk(K_COLON, p, OB'(1), E_NONE);
        end
        CH_LBRACE: begin
          f_emit = 1'b1;
          f_tok  = mk(K_LBRACE, p, OB'(1), E_NONE);
        end
        CH_RBRACE: begin
          f_emit = 1'b1;
          f_tok  = mk(K_RBRACE, p, OB'(1), E_NONE);
        end
        CH_GT:     f_mode = M_GT;
        CH_LT:     f_mode = M_LT;
        CH_QMARK:  f_mode = M_QM;
        CH_QUOTE: begin
          f_tb   = p + OB'(1);
          f_mode = M_STR;
        end
        default: begin
          if (c == CH_MINUS || is_digit(c)) begin
            f_mode = M_NUM;
            f_ds   = is_digit(c);
            f_dot  = 1'b0;
            f_lwd  = 1'b0;
          end else if (is_ident(c)) begin
            f_mode = M_IDENT;
            f_kw   = (c == CH_LOW_Y) ? KW_Y : (c == CH_LOW_N) ? KW_N : KW_NONE;
          end else begin
            // Bad character: error token, then ignore the rest of the text.
            f_emit = 1'b1;
            f_mode = M_ERR;
          end
        end
      endcase
    end
  end

  always_comb begin
    logic use_fresh;
    use_fresh = 1'b0;
    m   = mode;
    tb  = token_begin;
    ds  = digit_seen;
    dt  = dot_seen;
    lwd = last_was_dot;
    kw  = keyword_match;
    n   = 2'd0;
    tv  = '0;

    case (mode)
      M_START: begin
        if (c == CH_BOM0) begin
          if (fin) begin
            tv[n] = mk(K_ERROR, '0, '0, E_BAD_CHAR);
            n = n + 2'd1;
            m = M_ERR;
          end else begin
            m = M_BOM1;
          end
        end else begin
          use_fresh = 1'b1;
        end
      end
      M_BOM1: begin
        if (c == CH_BOM1 && !fin) begin
          m = M_BOM2;
        end else begin
          tv[n] = mk(K_ERROR, '0, '0, E_BAD_CHAR);
          n = n + 2'd1;
          m = M_ERR;
        end
      end
      M_BOM2: begin
        if (fin) begin
          tv[n] = mk(K_ERROR, '0, '0, E_BAD_CHAR);
          n = n + 2'd1;
          m = M_ERR;
        end else begin
          m = M_IDLE;
        end
      end
      M_COMMENT: begin
        if (c == CH_NL) m = M_IDLE;
      end
      M_GT, M_LT: begin
        if (c == CH_EQ) begin
          tv[n] = mk((mode == M_GT) ? K_GE : K_LE, token_begin, OB'(2), E_NONE);
          n = n + 2'd1;
          m = M_IDLE;
        end else begin
          tv[n] = mk((mode == M_GT) ? K_GT : K_LT, token_begin, OB'(1), E_NONE);
          n = n + 2'd1;
          use_fresh = 1'b1;
        end
      end
      M_QM: begin
        if (c == CH_EQ) begin
          tv[n] = mk(K_QE, token_begin, OB'(2), E_NONE);
          n = n + 2'd1;
          m = M_IDLE;
        end else begin
          tv[n] = mk(K_ERROR, token_begin, '0, E_LONE_QM);
          n = n + 2'd1;
          m = M_ERR;
        end
      end
      M_NUM: begin
        if (c == CH_DOT) begin
          if (dot_seen || !digit_seen) begin
            tv[n] = mk(K_ERROR, p, '0, E_DOT);
            n = n + 2'd1;
            m = M_ERR;
          end else begin
            dt  = 1'b1;
            lwd = 1'b1;
          end
        end else if (is_digit(c)) begin
          ds  = 1'b1;
          lwd = 1'b0;
        end else if (!digit_seen || last_was_dot) begin
          tv[n] = mk(K_ERROR, p, '0, E_NUM_END);
          n = n + 2'd1;
          m = M_ERR;
        end else begin
          tv[n] = mk(K_NUM, token_begin, p - token_begin, E_NONE);
          n = n + 2'd1;
          use_fresh = 1'b1;
        end
      end
      M_STR: begin
        if (c == CH_QUOTE) begin
          tv[n] = mk(K_STR, token_begin, p - token_begin, E_NONE);
          n = n + 2'd1;
          m = M_IDLE;
        end
      end
      M_IDENT: begin
        if (is_ident(c)) begin
          if (keyword_match == KW_Y && c == CH_LOW_E) kw = KW_YE;
          else if (keyword_match == KW_YE && c == CH_LOW_S) kw = KW_YES;
          else if (keyword_match == KW_N && c == CH_LOW_O) kw = KW_NO;
          else kw = KW_NONE;
        end else begin
          tv[n] = mk(ident_kind(keyword_match), token_begin, p - token_begin, E_NONE);
          n = n + 2'd1;
          use_fresh = 1'b1;
        end
      end
      M_ERR: begin
      end
      default: use_fresh = 1'b1;
    endcase

    if (use_fresh) begin
      m   = f_mode;
      tb  = f_tb;
      ds  = f_ds;
      dt  = f_dot;
      lwd = f_lwd;
      kw  = f_kw;
      if (f_emit) begin
        tv[n] = f_tok;
        n = n + 2'd1;
      end
    end

    // End of text: flush the pending token, then the end token.
    if (fin) begin
      case (m)
        M_GT: begin
          tv[n] = mk(K_GT, tb, OB'(1), E_NONE);
          n = n + 2'd1;
        end
        M_LT: begin
          tv[n] = mk(K_LT, tb, OB'(1), E_NONE);
          n = n + 2'd1;
        end
        M_QM: begin
          tv[n] = mk(K_ERROR, tb, '0, E_LONE_QM);
          n = n + 2'd1;
        end
        M_NUM: begin
          if (!ds || lwd) tv[n] = mk(K_ERROR, p_end, '0, E_NUM_END);
          else tv[n] = mk(K_NUM, tb, p_end - tb, E_NONE);
          n = n + 2'd1;
        end
        M_STR: begin
          tv[n] = mk(K_ERROR, p_end, '0, E_OPEN_STR);
          n = n + 2'd1;
        end
        M_IDENT: begin
          tv[n] = mk(ident_kind(kw), tb, p_end - tb, E_NONE);
          n = n + 2'd1;
        end
        M_BOM1, M_BOM2: begin
          tv[n] = mk(K_ERROR, '0, '0, E_BAD_CHAR);
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
      tv[n] = mk(K_END, p_end, '0, E_NONE);
      n = n + 2'd1;
    end

    if (n != 2'd0) tv[n - 2'd1].last = 1'b1;
  end

  assign tok_cnt = n;
  assign toks    = tv;

  always_comb begin
    if (fin) begin
      mode_next          = M_START;
      byte_offset_next   = '0;
      token_begin_next   = '0;
      digit_seen_next    = 1'b0;
      dot_seen_next      = 1'b0;
      last_was_dot_next  = 1'b0;
      keyword_match_next = KW_NONE;
    end else begin
      mode_next          = m;
      byte_offset_next   = p_end;
      token_begin_next   = tb;
      digit_seen_next    = ds;
      dot_seen_next      = dt;
      last_was_dot_next  = lwd;
      keyword_match_next = kw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_START;
      byte_offset   <= '0;
      token_begin   <= '0;
      digit_seen    <= 1'b0;
      dot_seen      <= 1'b0;
      last_was_dot  <= 1'b0;
      keyword_match <= KW_NONE;
    end else if (go) begin
      mode          <= mode_next;
      byte_offset   <= byte_offset_next;
      token_begin   <= token_begin_next;
      digit_seen    <= digit_seen_next;
      dot_seen      <= dot_seen_next;
      last_was_dot  <= last_was_dot_next;
      keyword_match <= keyword_match_next;
    end
  end

  // The final byte always yields at least the end token.
  a_final_has_end: assert property (@(posedge clk) disable iff (rst)
    go && fin |-> tok_cnt != 2'd0)
    else $error("final byte produced no token");

  // After the final byte the lexer is back at the start of a new text.
  a_final_restarts: assert property (@(posedge clk) disable iff (rst)
    go && fin |=> mode == M_START && byte_offset == '0)
    else $error("lexer did not restart after final byte");

  // In the error mode nothing is emitted until the last byte.
  a_err_silent: assert property (@(posedge clk) disable iff (rst)
    go && !fin && mode == M_ERR |-> tok_cnt == 2'd0)
    else $error("token emitted while ignoring bytes after an error");

endmodule

### rtl/cfglex_fifo.sv
// Token queue: takes up to three tokens per cycle, hands out one per beat.
module cfglex_fifo (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [1:0]               push_cnt,
  input  cfglex_pkg::token_t [2:0] push_data,
  output logic                     space,
  output logic                     out_valid,
  input  logic                     out_stall,
  output cfglex_pkg::token_t       head
);
  import cfglex_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  token_t          mem [FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic            pop;

  assign out_valid  = (count != '0);
  assign pop        = out_valid && !out_stall;
  assign head       = mem[rd_ptr];
  assign space      = (count <= CW'(FIFO_DEPTH - MAX_TOKENS));
  assign count_next = count + CW'(push_cnt) - CW'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TOKENS; i++) begin
      if (2'(i) < push_cnt) mem[wr_ptr + PW'(i)] <= push_data[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_cnt);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(FIFO_DEPTH))
    else $error("token queue overflow");

  a_push_with_space: assert property (@(posedge clk) disable iff (rst)
    push_cnt != 2'd0 |-> space)
    else $error("tokens pushed without room for a full byte");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    count != CW'(FIFO_DEPTH) |-> PW'(wr_ptr - rd_ptr) == PW'(count))
    else $error("queue pointers disagree with count");

endmodule

### rtl/config_text_lexer_unit.sv
// Top level of the streaming key/value configuration text lexer.
//
//  Channel | Direction | Handshake            | Beat payload
//  --------+-----------+----------------------+----------------------------------------
//  input   | in        | in_valid / in_stall  | text_byte, final_byte
//  output  | out       | out_valid / out_stall| token_kind, token_start, token_length,
//          |           |                      | error_code, run_last
//
// One text byte is accepted per cycle while in_stall is low. An accepted byte
// sits in the input register, where the lexer decodes it against the
// current mode; when the byte retires it writes zero to three tokens into
// an eight-entry token queue, from whose head the tokens leave in order.
// The output port moves one token per beat, so a byte that yields two or
// three tokens (a flush at the final byte, or a '>' ended by a punctuation
// byte) takes that many output beats; the queue absorbs such bursts.
// in_stall rises only while the registered byte cannot move on because the
// queue has fewer than three free entries. That happens when out_stall
// holds tokens back, or when a run of bytes yields more tokens than one per
// byte (for example many one-byte texts, each giving a token and an end
// token). Reset is synchronous and clears the lexer to the start of a text,
// empties the queue and drops any registered byte.
module config_text_lexer_unit #(
  parameter int OFFSET_BITS = cfglex_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  text_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  token_kind,
  output logic [23:0] token_start,
  output logic [23:0] token_length,
  output logic [2:0]  error_code,
  output logic        run_last
);
  import cfglex_pkg::*;

  // Input register: the byte under decode.
  logic         s_valid;
  logic [7:0]   s_byte;
  logic         s_final;
  logic         s_valid_next;

  logic         space;
  logic         advance;
  logic         in_take;
  logic [1:0]   tok_cnt;
  token_t [2:0] toks;
  token_t       head;

  // The registered byte is decoded and retired whenever the queue has room
  // for the largest burst one byte can produce.
  assign advance  = s_valid && space;
  assign in_stall = s_valid && !space;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s_valid_next = s_valid;
    if (in_take) s_valid_next = 1'b1;
    else if (advance) s_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= s_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s_byte  <= text_byte;
      s_final <= final_byte;
    end
  end

  cfglex_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .go      (advance),
    .c       (s_byte),
    .fin     (s_final),
    .tok_cnt (tok_cnt),
    .toks    (toks)
  );

  // Only tokens of a byte that actually retires go into the queue.
  cfglex_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (advance ? tok_cnt : 2'd0),
    .push_data (toks),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign error_code   = head.code;
  assign run_last     = head.last;

endmodule
